// ===== design/sdlb_pkg.sv =====
// sdlb_pkg: shared constants and codes for the spatial distance lower bound
// no dependencies; imported by sdlb_div and spatial_distance_lower_bound_top
`default_nettype none

package sdlb_pkg;

  localparam int DIST_W = 32;

  typedef enum logic [1:0] {
    ST_NORMAL    = 2'd0,
    ST_COINCIDE  = 2'd1,
    ST_COLLINEAR = 2'd2,
    ST_SAT       = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ===== design/sdlb_div.sv =====
// sdlb_div: pipelined restoring divider, one quotient bit per stage
// depends on sdlb_pkg (quotient width); carries a tag alongside each request
`default_nettype none

module sdlb_div import sdlb_pkg::*; #(
  parameter int NW = 66,
  parameter int DW = 33,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] tag,
  output logic               q_valid,
  output logic [DIST_W-1:0]  quo,
  output logic               ovf,
  output logic [SW-1:0]      q_tag
);

  localparam int QW = DIST_W;
  localparam int HW = NW - QW;

  logic [QW:0]   v;
  logic [DW-1:0] rem [QW+1];
  logic [QW-1:0] acc [QW+1];
  logic [DW-1:0] d   [QW+1];
  logic [QW:0]   o;
  logic [SW-1:0] sd  [QW+1];
  logic [HW-1:0] hi;

  // quotient overflows the output width exactly when the high part >= divisor
  assign hi = num[NW-1:QW];

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else     v[0] <= valid;
  end

  always_ff @(posedge clk) begin
    rem[0] <= hi[DW-1:0];
    acc[0] <= num[QW-1:0];
    d[0]   <= den;
    o[0]   <= (hi >= HW'(den));
    sd[0]  <= tag;
  end

  for (genvar g = 0; g < QW; g++) begin : step
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;

    assign t    = {rem[g], acc[g][QW-1]};
    assign diff = t - {1'b0, d[g]};
    assign ge   = (t >= {1'b0, d[g]});

    always_ff @(posedge clk) begin
      if (rst) v[g+1] <= 1'b0;
      else     v[g+1] <= v[g];
    end

    always_ff @(posedge clk) begin
      rem[g+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
      acc[g+1] <= {acc[g][QW-2:0], ge};
      d[g+1]   <= d[g];
      o[g+1]   <= o[g];
      sd[g+1]  <= sd[g];
    end
  end

  assign q_valid = v[QW];
  assign quo     = acc[QW];
  assign ovf     = o[QW];
  assign q_tag   = sd[QW];

endmodule

`default_nettype wire

// ===== design/sdlb_sqrt.sv =====
// sdlb_sqrt: pipelined floor square root, one root bit per stage
// no package dependency; carries a tag alongside each request
`default_nettype none

module sdlb_sqrt #(
  parameter int VW = 64,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          valid,
  input  wire logic [VW-1:0] rad,
  input  wire logic [SW-1:0] tag,
  output logic               r_valid,
  output logic [VW/2-1:0]    root,
  output logic [SW-1:0]      r_tag
);

  localparam int RW = VW / 2;

  logic [RW:0]   v;
  logic [VW-1:0] rd  [RW+1];
  logic [RW+1:0] rem [RW+1];
  logic [RW-1:0] rt  [RW+1];
  logic [SW-1:0] sd  [RW+1];

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else     v[0] <= valid;
  end

  always_ff @(posedge clk) begin
    rd[0]  <= rad;
    rem[0] <= '0;
    rt[0]  <= '0;
    sd[0]  <= tag;
  end

  for (genvar g = 0; g < RW; g++) begin : step
    logic [RW+2:0] r4;
    logic [RW+2:0] trial;
    logic [RW+2:0] diff;
    logic          ge;

    assign r4    = {rem[g][RW:0], rd[g][VW-1:VW-2]};
    assign trial = {1'b0, rt[g], 2'b01};
    assign diff  = r4 - trial;
    assign ge    = (r4 >= trial);

    always_ff @(posedge clk) begin
      if (rst) v[g+1] <= 1'b0;
      else     v[g+1] <= v[g];
    end

    always_ff @(posedge clk) begin
      rem[g+1] <= ge ? diff[RW+1:0] : r4[RW+1:0];
      rt[g+1]  <= {rt[g][RW-2:0], ge};
      rd[g+1]  <= {rd[g][VW-3:0], 2'b00};
      sd[g+1]  <= sd[g];
    end
  end

  assign r_valid = v[RW];
  assign root    = rt[RW];
  assign r_tag   = sd[RW];

endmodule

`default_nettype wire

// ===== design/spatial_distance_lower_bound_top.sv =====
// spatial_distance_lower_bound_top: places two points by trilateration from
// three anchors and returns their distance; uses sdlb_pkg, sdlb_div, sdlb_sqrt
//
// channel   direction  handshake            payload
// request   in         start & !busy        dist_f_a1..3, dist_t_a1..3, dist_a1_a2,
//                                           dist_a1_a3, dist_a2_a3
// result    out        done (one cycle)     bound_distance, status_code
//
// one request per clock cycle while busy is low, fully pipelined; every stage advances each cycle
// the pipeline is 181 register stages deep, set by the chain of two 33-stage dividers and
// three square roots (33, 33 and 35 stages) that the geometry puts in series
// busy is high only during reset; the result side never stalls, so nothing waits
// reset clears the valid bits of every stage; data registers are not reset
`default_nettype none

module spatial_distance_lower_bound_top import sdlb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [DIST_W-1:0] dist_f_a1,
  input  wire logic [DIST_W-1:0] dist_f_a2,
  input  wire logic [DIST_W-1:0] dist_f_a3,
  input  wire logic [DIST_W-1:0] dist_t_a1,
  input  wire logic [DIST_W-1:0] dist_t_a2,
  input  wire logic [DIST_W-1:0] dist_t_a3,
  input  wire logic [DIST_W-1:0] dist_a1_a2,
  input  wire logic [DIST_W-1:0] dist_a1_a3,
  input  wire logic [DIST_W-1:0] dist_a2_a3,
  output logic                   done,
  output logic [DIST_W-1:0]      bound_distance,
  output logic [1:0]             status_code
);

  localparam int W   = DIST_W;
  localparam int SQW = 2 * W;       // square of a distance
  localparam int NW  = SQW + 2;     // signed sum of squares, also divider numerator
  localparam int CW  = W + 1;       // signed coordinate
  localparam int PW  = 2 * CW;      // signed coordinate product
  localparam int YW  = SQW + 4;     // signed y numerator
  localparam int ZW  = SQW + 3;     // signed z radicand
  localparam int DXW = W + 1;       // magnitude of a coordinate difference
  localparam int SSW = 2 * DXW + 2; // sum of three squared differences

  typedef struct packed {
    logic                 neg;
    logic signed [NW-1:0] cf;
    logic signed [NW-1:0] ct;
    logic [SQW-1:0]       sqf;
    logic [SQW-1:0]       sqt;
    logic [SQW-1:0]       sqa;
    logic                 coinc;
  } xtag_t;

  typedef struct packed {
    logic signed [YW-1:0] nyf;
    logic signed [YW-1:0] nyt;
    logic signed [NW-1:0] zpf;
    logic signed [NW-1:0] zpt;
    logic signed [CW-1:0] xf;
    logic signed [CW-1:0] xt;
    logic                 sat;
    logic                 coinc;
    logic                 coll;
  } ytag_t;

  typedef struct packed {
    logic                 neg;
    logic signed [NW-1:0] zpf;
    logic signed [NW-1:0] zpt;
    logic signed [CW-1:0] xf;
    logic signed [CW-1:0] xt;
    logic                 sat;
    logic                 coinc;
    logic                 coll;
  } ftag_t;

  typedef struct packed {
    logic [DXW-1:0] dxm;
    logic           sat;
    logic           coinc;
    logic           coll;
  } ztag_t;

  typedef struct packed {
    logic sat;
    logic coinc;
    logic coll;
  } rtag_t;

  // clamp a truncated quotient to the output width and give it its sign back
  function automatic logic signed [CW-1:0] apply_sign(logic [W-1:0] q, logic ov, logic neg);
    logic [W-1:0] m;
    m = ov ? '1 : q;
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  assign busy = rst;

  // ---------------------------------------------------------------- stage a
  // all nine squares in parallel
  logic           va;
  logic [SQW-1:0] sq_pf1, sq_pf2, sq_pf3, sq_pt1, sq_pt2, sq_pt3;
  logic [SQW-1:0] sq_a12, sq_a13, sq_a23;
  logic [W-1:0]   a12_a;
  logic           coinc_a;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else     va <= start && !busy;
  end

  always_ff @(posedge clk) begin
    sq_pf1  <= SQW'(dist_f_a1) * SQW'(dist_f_a1);
    sq_pf2  <= SQW'(dist_f_a2) * SQW'(dist_f_a2);
    sq_pf3  <= SQW'(dist_f_a3) * SQW'(dist_f_a3);
    sq_pt1  <= SQW'(dist_t_a1) * SQW'(dist_t_a1);
    sq_pt2  <= SQW'(dist_t_a2) * SQW'(dist_t_a2);
    sq_pt3  <= SQW'(dist_t_a3) * SQW'(dist_t_a3);
    sq_a12  <= SQW'(dist_a1_a2) * SQW'(dist_a1_a2);
    sq_a13  <= SQW'(dist_a1_a3) * SQW'(dist_a1_a3);
    sq_a23  <= SQW'(dist_a2_a3) * SQW'(dist_a2_a3);
    a12_a   <= dist_a1_a2;
    coinc_a <= (dist_a1_a2 == '0);
  end

  // ---------------------------------------------------------------- stage b
  // law-of-cosines numerators for x and the constant part of the y numerator
  logic                 vb;
  logic signed [NW-1:0] nx3_b, nxf_b, nxt_b, cf_b, ct_b;
  logic [SQW-1:0]       sqf_b, sqt_b, sqa_b;
  logic [W-1:0]         a12_b;
  logic                 coinc_b;

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else     vb <= va;
  end

  always_ff @(posedge clk) begin
    nx3_b   <= $signed({2'b00, sq_a13}) + $signed({2'b00, sq_a12}) - $signed({2'b00, sq_a23});
    nxf_b   <= $signed({2'b00, sq_pf1}) + $signed({2'b00, sq_a12}) - $signed({2'b00, sq_pf2});
    nxt_b   <= $signed({2'b00, sq_pt1}) + $signed({2'b00, sq_a12}) - $signed({2'b00, sq_pt2});
    cf_b    <= $signed({2'b00, sq_pf1}) + $signed({2'b00, sq_a13}) - $signed({2'b00, sq_pf3});
    ct_b    <= $signed({2'b00, sq_pt1}) + $signed({2'b00, sq_a13}) - $signed({2'b00, sq_pt3});
    sqf_b   <= sq_pf1;
    sqt_b   <= sq_pt1;
    sqa_b   <= sq_a13;
    a12_b   <= a12_a;
    coinc_b <= coinc_a;
  end

  // --------------------------------------------------------------- stage b2
  // sign and magnitude for the dividers
  logic          vb2;
  logic [NW-1:0] mx3, mxf, mxt;
  logic          nxf, nxt;
  logic [W:0]    den_x;
  xtag_t         xtag;

  always_ff @(posedge clk) begin
    if (rst) vb2 <= 1'b0;
    else     vb2 <= vb;
  end

  always_ff @(posedge clk) begin
    mx3        <= nx3_b[NW-1] ? NW'(-nx3_b) : NW'(nx3_b);
    mxf        <= nxf_b[NW-1] ? NW'(-nxf_b) : NW'(nxf_b);
    mxt        <= nxt_b[NW-1] ? NW'(-nxt_b) : NW'(nxt_b);
    nxf        <= nxf_b[NW-1];
    nxt        <= nxt_b[NW-1];
    den_x      <= {a12_b, 1'b0};
    xtag.neg   <= nx3_b[NW-1];
    xtag.cf    <= cf_b;
    xtag.ct    <= ct_b;
    xtag.sqf   <= sqf_b;
    xtag.sqt   <= sqt_b;
    xtag.sqa   <= sqa_b;
    xtag.coinc <= coinc_b;
  end

  // --------------------------------------------------------- x dividers
  logic         v_x3d, v_xfd, v_xtd;
  logic [W-1:0] q_x3, q_xf, q_xt;
  logic         o_x3, o_xf, o_xt;
  xtag_t        xtag_q;
  logic         neg_xf_q, neg_xt_q;

  sdlb_div #(.NW(NW), .DW(W + 1), .SW($bits(xtag_t))) u_div_x3 (
    .clk, .rst, .valid(vb2), .num(mx3), .den(den_x), .tag(xtag),
    .q_valid(v_x3d), .quo(q_x3), .ovf(o_x3), .q_tag(xtag_q)
  );

  sdlb_div #(.NW(NW), .DW(W + 1), .SW(1)) u_div_xf (
    .clk, .rst, .valid(vb2), .num(mxf), .den(den_x), .tag(nxf),
    .q_valid(v_xfd), .quo(q_xf), .ovf(o_xf), .q_tag(neg_xf_q)
  );

  sdlb_div #(.NW(NW), .DW(W + 1), .SW(1)) u_div_xt (
    .clk, .rst, .valid(vb2), .num(mxt), .den(den_x), .tag(nxt),
    .q_valid(v_xtd), .quo(q_xt), .ovf(o_xt), .q_tag(neg_xt_q)
  );

  // ---------------------------------------------------------------- stage c
  logic                 vc;
  logic signed [CW-1:0] x3_c, xf_c, xt_c;
  logic                 sat_c;
  xtag_t                xtag_c;

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else     vc <= v_x3d;
  end

  always_ff @(posedge clk) begin
    x3_c   <= apply_sign(q_x3, o_x3, xtag_q.neg);
    xf_c   <= apply_sign(q_xf, o_xf, neg_xf_q);
    xt_c   <= apply_sign(q_xt, o_xt, neg_xt_q);
    sat_c  <= o_x3 || o_xf || o_xt;
    xtag_c <= xtag_q;
  end

  // ---------------------------------------------------------------- stage d
  // coordinate products
  logic                 vd;
  logic signed [PW-1:0] p_x3x3, p_xfx3, p_xtx3, p_xfxf, p_xtxt;
  logic signed [CW-1:0] xf_d, xt_d;
  logic                 sat_d;
  xtag_t                xtag_d;

  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else     vd <= vc;
  end

  always_ff @(posedge clk) begin
    p_x3x3 <= PW'(x3_c) * PW'(x3_c);
    p_xfx3 <= PW'(xf_c) * PW'(x3_c);
    p_xtx3 <= PW'(xt_c) * PW'(x3_c);
    p_xfxf <= PW'(xf_c) * PW'(xf_c);
    p_xtxt <= PW'(xt_c) * PW'(xt_c);
    xf_d   <= xf_c;
    xt_d   <= xt_c;
    sat_d  <= sat_c;
    xtag_d <= xtag_c;
  end

  // ---------------------------------------------------------------- stage e
  // anchor 3 height squared, y numerators, partial z radicands
  logic                 ve;
  logic signed [NW-1:0] ny3_e;
  logic                 coll_e;
  ytag_t                ytag;
  logic signed [NW-1:0] ny3_n;
  logic [SQW-1:0]       rad_y;

  assign ny3_n = $signed({2'b00, xtag_d.sqa}) - p_x3x3;

  always_ff @(posedge clk) begin
    if (rst) ve <= 1'b0;
    else     ve <= vd;
  end

  always_ff @(posedge clk) begin
    ny3_e      <= ny3_n;
    coll_e     <= ny3_n[NW-1] || (ny3_n == '0);
    ytag.nyf   <= $signed({{2{xtag_d.cf[NW-1]}}, xtag_d.cf})
                - $signed({p_xfx3[PW-1], p_xfx3, 1'b0});
    ytag.nyt   <= $signed({{2{xtag_d.ct[NW-1]}}, xtag_d.ct})
                - $signed({p_xtx3[PW-1], p_xtx3, 1'b0});
    ytag.zpf   <= $signed({2'b00, xtag_d.sqf}) - p_xfxf;
    ytag.zpt   <= $signed({2'b00, xtag_d.sqt}) - p_xtxt;
    ytag.xf    <= xf_d;
    ytag.xt    <= xt_d;
    ytag.sat   <= sat_d;
    ytag.coinc <= xtag_d.coinc;
    ytag.coll  <= ny3_n[NW-1] || (ny3_n == '0);
  end

  // a non-positive height squared marks the anchors collinear; feed zero then
  assign rad_y = coll_e ? '0 : ny3_e[SQW-1:0];

  // ----------------------------------------------------------- y3 square root
  logic         v_y3;
  logic [W-1:0] y3;
  ytag_t        ytag_q;

  sdlb_sqrt #(.VW(SQW), .SW($bits(ytag_t))) u_sqrt_y3 (
    .clk, .rst, .valid(ve), .rad(rad_y), .tag(ytag),
    .r_valid(v_y3), .root(y3), .r_tag(ytag_q)
  );

  // ---------------------------------------------------------------- stage f
  logic          vf;
  logic [W:0]    den_y;
  logic [YW-1:0] abs_yf, abs_yt;
  logic [NW-1:0] myf, myt;
  logic          nyt_neg;
  ftag_t         ftag;

  assign abs_yf = ytag_q.nyf[YW-1] ? YW'(-ytag_q.nyf) : YW'(ytag_q.nyf);
  assign abs_yt = ytag_q.nyt[YW-1] ? YW'(-ytag_q.nyt) : YW'(ytag_q.nyt);

  always_ff @(posedge clk) begin
    if (rst) vf <= 1'b0;
    else     vf <= v_y3;
  end

  always_ff @(posedge clk) begin
    den_y      <= {y3, 1'b0};
    myf        <= abs_yf[NW-1:0];
    myt        <= abs_yt[NW-1:0];
    nyt_neg    <= ytag_q.nyt[YW-1];
    ftag.neg   <= ytag_q.nyf[YW-1];
    ftag.zpf   <= ytag_q.zpf;
    ftag.zpt   <= ytag_q.zpt;
    ftag.xf    <= ytag_q.xf;
    ftag.xt    <= ytag_q.xt;
    ftag.sat   <= ytag_q.sat;
    ftag.coinc <= ytag_q.coinc;
    ftag.coll  <= ytag_q.coll;
  end

  // --------------------------------------------------------- y dividers
  logic         v_yfd, v_ytd;
  logic [W-1:0] q_yf, q_yt;
  logic         o_yf, o_yt;
  ftag_t        ftag_q;
  logic         neg_yt_q;

  sdlb_div #(.NW(NW), .DW(W + 1), .SW($bits(ftag_t))) u_div_yf (
    .clk, .rst, .valid(vf), .num(myf), .den(den_y), .tag(ftag),
    .q_valid(v_yfd), .quo(q_yf), .ovf(o_yf), .q_tag(ftag_q)
  );

  sdlb_div #(.NW(NW), .DW(W + 1), .SW(1)) u_div_yt (
    .clk, .rst, .valid(vf), .num(myt), .den(den_y), .tag(nyt_neg),
    .q_valid(v_ytd), .quo(q_yt), .ovf(o_yt), .q_tag(neg_yt_q)
  );

  // ---------------------------------------------------------------- stage g
  logic                 vg;
  logic signed [CW-1:0] yf_g, yt_g;
  logic                 sat_g;
  ftag_t                ftag_g;

  always_ff @(posedge clk) begin
    if (rst) vg <= 1'b0;
    else     vg <= v_yfd;
  end

  always_ff @(posedge clk) begin
    yf_g   <= apply_sign(q_yf, o_yf, ftag_q.neg);
    yt_g   <= apply_sign(q_yt, o_yt, neg_yt_q);
    sat_g  <= ftag_q.sat || o_yf || o_yt;
    ftag_g <= ftag_q;
  end

  // ---------------------------------------------------------------- stage h
  logic                 vh;
  logic signed [PW-1:0] p_yfyf, p_ytyt;
  logic signed [CW:0]   dx_h, dy_h;
  logic signed [NW-1:0] zpf_h, zpt_h;
  rtag_t                rtag_h;

  always_ff @(posedge clk) begin
    if (rst) vh <= 1'b0;
    else     vh <= vg;
  end

  always_ff @(posedge clk) begin
    p_yfyf       <= PW'(yf_g) * PW'(yf_g);
    p_ytyt       <= PW'(yt_g) * PW'(yt_g);
    dx_h         <= $signed({ftag_g.xf[CW-1], ftag_g.xf}) - $signed({ftag_g.xt[CW-1], ftag_g.xt});
    dy_h         <= $signed({yf_g[CW-1], yf_g}) - $signed({yt_g[CW-1], yt_g});
    zpf_h        <= ftag_g.zpf;
    zpt_h        <= ftag_g.zpt;
    rtag_h.sat   <= sat_g;
    rtag_h.coinc <= ftag_g.coinc;
    rtag_h.coll  <= ftag_g.coll;
  end

  // ---------------------------------------------------------------- stage i
  logic                 vi;
  logic signed [ZW-1:0] nzf, nzt;
  logic [CW:0]          absdx, absdy;
  logic [DXW-1:0]       dym_i;
  ztag_t                ztag;
  logic [SQW-1:0]       rad_zf, rad_zt;

  assign absdx = dx_h[CW] ? (CW + 1)'(-dx_h) : (CW + 1)'(dx_h);
  assign absdy = dy_h[CW] ? (CW + 1)'(-dy_h) : (CW + 1)'(dy_h);

  always_ff @(posedge clk) begin
    if (rst) vi <= 1'b0;
    else     vi <= vh;
  end

  always_ff @(posedge clk) begin
    nzf        <= $signed({zpf_h[NW-1], zpf_h}) - $signed({p_yfyf[PW-1], p_yfyf});
    nzt        <= $signed({zpt_h[NW-1], zpt_h}) - $signed({p_ytyt[PW-1], p_ytyt});
    ztag.dxm   <= absdx[DXW-1:0];
    dym_i      <= absdy[DXW-1:0];
    ztag.sat   <= rtag_h.sat;
    ztag.coinc <= rtag_h.coinc;
    ztag.coll  <= rtag_h.coll;
  end

  // a non-positive z radicand clamps the height to zero
  assign rad_zf = (!nzf[ZW-1] && nzf != '0) ? nzf[SQW-1:0] : '0;
  assign rad_zt = (!nzt[ZW-1] && nzt != '0) ? nzt[SQW-1:0] : '0;

  // ------------------------------------------------------------ z square roots
  logic           v_zf, v_zt;
  logic [W-1:0]   zf, zt;
  ztag_t          ztag_q;
  logic [DXW-1:0] dym_q;

  sdlb_sqrt #(.VW(SQW), .SW($bits(ztag_t))) u_sqrt_zf (
    .clk, .rst, .valid(vi), .rad(rad_zf), .tag(ztag),
    .r_valid(v_zf), .root(zf), .r_tag(ztag_q)
  );

  sdlb_sqrt #(.VW(SQW), .SW(DXW)) u_sqrt_zt (
    .clk, .rst, .valid(vi), .rad(rad_zt), .tag(dym_i),
    .r_valid(v_zt), .root(zt), .r_tag(dym_q)
  );

  // ---------------------------------------------------------------- stage j
  logic           vj;
  logic [DXW-1:0] dxm_j, dym_j;
  logic [W-1:0]   dz_j;
  rtag_t          rtag_j;

  always_ff @(posedge clk) begin
    if (rst) vj <= 1'b0;
    else     vj <= v_zf;
  end

  always_ff @(posedge clk) begin
    dxm_j        <= ztag_q.dxm;
    dym_j        <= dym_q;
    dz_j         <= (zf > zt) ? zf - zt : zt - zf;
    rtag_j.sat   <= ztag_q.sat;
    rtag_j.coinc <= ztag_q.coinc;
    rtag_j.coll  <= ztag_q.coll;
  end

  // ---------------------------------------------------------------- stage k
  logic               vk;
  logic [2*DXW-1:0]   dx2, dy2;
  logic [SQW-1:0]     dz2;
  rtag_t              rtag_k;

  always_ff @(posedge clk) begin
    if (rst) vk <= 1'b0;
    else     vk <= vj;
  end

  always_ff @(posedge clk) begin
    dx2    <= (2 * DXW)'(dxm_j) * (2 * DXW)'(dxm_j);
    dy2    <= (2 * DXW)'(dym_j) * (2 * DXW)'(dym_j);
    dz2    <= SQW'(dz_j) * SQW'(dz_j);
    rtag_k <= rtag_j;
  end

  // ---------------------------------------------------------------- stage l
  logic           vl;
  logic [SSW-1:0] ssum;
  rtag_t          rtag_l;

  always_ff @(posedge clk) begin
    if (rst) vl <= 1'b0;
    else     vl <= vk;
  end

  always_ff @(posedge clk) begin
    ssum   <= SSW'(dx2) + SSW'(dy2) + SSW'(dz2);
    rtag_l <= rtag_k;
  end

  // -------------------------------------------------------- final square root
  logic             v_r;
  logic [SSW/2-1:0] root_r;
  rtag_t            rtag_r;

  sdlb_sqrt #(.VW(SSW), .SW($bits(rtag_t))) u_sqrt_r (
    .clk, .rst, .valid(vl), .rad(ssum), .tag(rtag_l),
    .r_valid(v_r), .root(root_r), .r_tag(rtag_r)
  );

  // ---------------------------------------------------------------- output
  // coincident anchors win over collinear, which wins over saturation
  logic big;

  assign big = (root_r[SSW/2-1:W] != '0);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v_r;
  end

  always_ff @(posedge clk) begin
    if (rtag_r.coinc) begin
      bound_distance <= '0;
      status_code    <= ST_COINCIDE;
    end else if (rtag_r.coll) begin
      bound_distance <= '0;
      status_code    <= ST_COLLINEAR;
    end else begin
      bound_distance <= big ? '1 : root_r[W-1:0];
      status_code    <= (big || rtag_r.sat) ? ST_SAT : ST_NORMAL;
    end
  end

`ifndef NO_ASSERTIONS
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status_code == ST_COINCIDE || status_code == ST_COLLINEAR)
      |-> bound_distance == '0)
    else $error("fault result with nonzero distance");

  a_xdiv_align: assert property (@(posedge clk) disable iff (rst)
    (v_x3d == v_xfd) && (v_x3d == v_xtd))
    else $error("x dividers out of step");

  a_ydiv_align: assert property (@(posedge clk) disable iff (rst)
    v_yfd == v_ytd)
    else $error("y dividers out of step");

  a_zsqrt_align: assert property (@(posedge clk) disable iff (rst)
    v_zf == v_zt)
    else $error("z square roots out of step");
`endif

endmodule

`default_nettype wire
